FILE: hdl/txc_pkg.sv
`default_nettype none

package txc_pkg;

    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-3:0] REG_TEXT_ATTR = '0;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] LF_CHAR    = 8'h0A;
    localparam logic [7:0] CR_CHAR    = 8'h0D;
    localparam logic [7:0] RESET_ATTR = 8'h07;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [4:0] target_row;
        logic [6:0] target_col;
    } req_t;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] read_char;
        logic [7:0] read_attr;
    } rsp_t;

endpackage

`default_nettype wire

FILE: hdl/text_console_cursor_scroll.sv
// Text console engine with a cursor and an on-chip screen store of ROWS x COLS cells.
// Requests arrive as transactions on the req channel (req_valid, req_stall, req) and
// each one produces exactly one transaction on the rsp channel (rsp_valid, rsp_stall,
// rsp) carrying the cursor position and, for a cell read, the cell contents.
// The text attribute register sits at byte address 0 of the APB port.
// A single sequencer drives one write port and one read port of the cell store.
// Set cursor, line feed and carriage return go straight to the completion state;
// an ordinary character first writes its cell and a cell read first reads it. A line
// feed on the last row scrolls the screen, one cell per cycle, moving rows up and
// blanking the last row; a wrap on the last row writes the character, then scrolls.
// Clear screen fills every cell. The result is registered as the engine returns to idle.
// After reset the store is swept to spaces with attribute 0x07, one cell per
// cycle over all ROWS*COLS cells (2000 by default), and req_stall stays high meanwhile.
// A finished result sits in an output register; while rsp_stall holds it there the
// engine can still accept one new request, and it waits before delivering that one.
`default_nettype none

module text_console_cursor_scroll
    import txc_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire req_t               req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output rsp_t                    rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int N  = ROWS * COLS;
    localparam int AW = $clog2(N);

    logic [7:0]    text_attr_reg;
    logic          attr_sel;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   mem_rdata;

    assign attr_sel = (paddr[PADDR_W-1:2] == REG_TEXT_ATTR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr_reg <= RESET_ATTR;
        end
        else if (psel && penable && pwrite && attr_sel)
        begin
            text_attr_reg <= pwdata[7:0];
        end
    end

    assign prdata = attr_sel ? PDATA_W'(text_attr_reg) : '0;
    assign pready = 1'b1;

    txc_engine #(
        .ROWS (ROWS),
        .COLS (COLS),
        .AW   (AW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .text_attr (text_attr_reg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    txc_cell_ram #(
        .DEPTH (N),
        .AW    (AW)
    ) u_cell_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

FILE: hdl/txc_cell_ram.sv
`default_nettype none

module txc_cell_ram
    import txc_pkg::*;
#(
    parameter int DEPTH = ROWS_DEF * COLS_DEF,
    parameter int AW    = $clog2(ROWS_DEF * COLS_DEF)
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [15:0]   wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [15:0]   rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/txc_engine.sv
`default_nettype none

module txc_engine
    import txc_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF,
    parameter int AW   = $clog2(ROWS_DEF * COLS_DEF)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire req_t          req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output rsp_t               rsp,
    input  wire logic [7:0]    text_attr,
    output logic               mem_we,
    output logic      [AW-1:0] mem_waddr,
    output logic      [15:0]   mem_wdata,
    output logic               mem_re,
    output logic      [AW-1:0] mem_raddr,
    input  wire logic [15:0]   mem_rdata
);

    localparam int N  = ROWS * COLS;
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int SW = $clog2(N + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PUT    = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_BLANK  = 3'd4;
    localparam logic [2:0] S_FILL   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic          boot_reg, boot_next;
    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [SW-1:0] scan_reg, scan_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [7:0]    char_reg, char_next;
    logic          is_read_reg, is_read_next;
    logic [7:0]    fill_attr_reg, fill_attr_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic [RW-1:0] trow_c;
    logic [CW-1:0] tcol_c;
    logic          accept;

    assign accept = req_valid && (state_reg == S_IDLE);

    always_comb
    begin
        if (32'(req.target_row) >= ROWS)
        begin
            trow_c = RW'(ROWS - 1);
        end
        else
        begin
            trow_c = RW'(req.target_row);
        end
        if (32'(req.target_col) >= COLS)
        begin
            tcol_c = CW'(COLS - 1);
        end
        else
        begin
            tcol_c = CW'(req.target_col);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        boot_next      = boot_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        scan_next      = scan_reg;
        addr_next      = addr_reg;
        char_next      = char_reg;
        is_read_next   = is_read_reg;
        fill_attr_next = fill_attr_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = scan_reg[AW-1:0];
        mem_wdata      = {text_attr, SPACE_CHAR};
        mem_re         = 1'b0;
        mem_raddr      = addr_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    char_next    = req.char_code;
                    is_read_next = (req.req_type == REQ_READ);
                    unique case (req.req_type)
                        REQ_PUT:
                        begin
                            if (req.char_code == LF_CHAR)
                            begin
                                cur_col_next = '0;
                                if (cur_row_reg == RW'(ROWS - 1))
                                begin
                                    scan_next  = SW'(COLS);
                                    state_next = S_SCROLL;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                    state_next   = S_DONE;
                                end
                            end
                            else if (req.char_code == CR_CHAR)
                            begin
                                cur_col_next = '0;
                                state_next   = S_DONE;
                            end
                            else
                            begin
                                addr_next  = AW'(32'(cur_row_reg) * COLS + 32'(cur_col_reg));
                                state_next = S_PUT;
                            end
                        end
                        REQ_SET:
                        begin
                            cur_row_next = trow_c;
                            cur_col_next = tcol_c;
                            state_next   = S_DONE;
                        end
                        REQ_CLEAR:
                        begin
                            cur_row_next   = '0;
                            cur_col_next   = '0;
                            scan_next      = '0;
                            fill_attr_next = text_attr;
                            state_next     = S_FILL;
                        end
                        REQ_READ:
                        begin
                            addr_next  = AW'(32'(trow_c) * COLS + 32'(tcol_c));
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = {text_attr, char_reg};
                if (cur_col_reg == CW'(COLS - 1))
                begin
                    cur_col_next = '0;
                    if (cur_row_reg == RW'(ROWS - 1))
                    begin
                        scan_next  = SW'(COLS);
                        state_next = S_SCROLL;
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg + 1'b1;
                        state_next   = S_DONE;
                    end
                end
                else
                begin
                    cur_col_next = cur_col_reg + 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_DONE;
            end
            S_SCROLL:
            begin
                mem_re    = (32'(scan_reg) < N);
                mem_raddr = scan_reg[AW-1:0];
                mem_we    = (32'(scan_reg) > COLS);
                mem_waddr = AW'(scan_reg - SW'(COLS + 1));
                mem_wdata = mem_rdata;
                if (32'(scan_reg) == N)
                begin
                    scan_next  = SW'((ROWS - 1) * COLS);
                    state_next = S_BLANK;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_BLANK:
            begin
                mem_we = 1'b1;
                if (32'(scan_reg) == N - 1)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = {fill_attr_reg, SPACE_CHAR};
                if (32'(scan_reg) == N - 1)
                begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.cursor_row = 5'(cur_row_reg);
                    rsp_next.cursor_col = 7'(cur_col_reg);
                    rsp_next.read_char  = is_read_reg ? mem_rdata[7:0] : 8'h00;
                    rsp_next.read_attr  = is_read_reg ? mem_rdata[15:8] : 8'h00;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            boot_reg      <= 1'b1;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            scan_reg      <= '0;
            fill_attr_reg <= RESET_ATTR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            boot_reg      <= boot_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            scan_reg      <= scan_next;
            fill_attr_reg <= fill_attr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        char_reg    <= char_next;
        is_read_reg <= is_read_next;
        rsp_reg     <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cur_row_reg) < ROWS) && (32'(cur_col_reg) < COLS))
        else $error("Cursor left the screen.");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != S_IDLE))
        else $error("Accepted transaction did not start work.");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("Result raised outside the completion state.");

    a_boot_blocks_requests: assert property (@(posedge clk) disable iff (!rst_n)
        boot_reg |-> (req_stall && !rsp_valid_reg))
        else $error("Requests taken during the power-up clearing pass.");

endmodule

`default_nettype wire
